// ----- hw/rtl/keyframe_interpolator_core_defines.svh -----
// assertion macros shared by the keyframe interpolator rtl
// depends on nothing; the asserting module provides clk_i and rst_ni
`ifndef KEYFRAME_INTERPOLATOR_CORE_DEFINES_SVH
`define KEYFRAME_INTERPOLATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define KFI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// when the trigger holds, the property must hold in the next cycle
`define KFI_ASSERT_NEXT(name, trig, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);
`else
`define KFI_ASSERT(name, prop, msg)
`define KFI_ASSERT_NEXT(name, trig, prop, msg)
`endif

`endif

// ----- hw/rtl/kfi_pkg.sv -----
// types and constants of the keyframe interpolator
// depends on nothing
package kfi_pkg;

  localparam int unsigned TimeW  = 16;
  localparam int unsigned PixW   = 16;
  localparam int unsigned ScaleW = 16;
  localparam int unsigned AlphaW = 8;
  localparam int unsigned MsW    = 32;
  localparam int unsigned FracW  = 17;  // 0..65536
  localparam int unsigned FiW    = 4;   // reported frame index
  localparam int unsigned InW    = 104;
  localparam int unsigned OutW   = 64;

  // request kinds on tuser
  localparam logic CmdAppend = 1'b0;
  localparam logic CmdTick   = 1'b1;

  typedef struct packed {
    logic [AlphaW-1:0] alpha;
    logic [ScaleW-1:0] scale;
    logic [PixW-1:0]   y;
    logic [PixW-1:0]   x;
    logic [TimeW-1:0]  time_ms;
  } kfi_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_NEXT,
    S_CHK_NEXT,
    S_CHK_LAST,
    S_GET_A,
    S_GET_B,
    S_DIV,
    S_LERP,
    S_DONE
  } kfi_state_e;

  typedef enum logic [1:0] {
    LANE_X,
    LANE_Y,
    LANE_SCALE,
    LANE_ALPHA
  } kfi_lane_e;

endpackage

// ----- hw/rtl/keyframe_interpolator_core.sv -----
// keyframe interpolator: keyframe table in a synchronous memory with linear interpolation
// depends on kfi_pkg and keyframe_interpolator_core_defines.svh
//
// One request in, one result out. An append request (tuser = 0) writes a keyframe into the
// next free slot of a MAX_FRAMES deep table when one is free, then answers. A tick request
// (tuser = 1) carries the current millisecond time; the first tick starts the animation.
// A tick walks the table through the single memory read port (next key, last key, current
// key, next key; one registered read each), then forms the Q1.16 fraction with a
// restoring divider at one quotient bit per cycle, then interpolates x, y, scale and alpha
// through one shared multiplier, one field per cycle. A fraction that saturates to one skips
// the divider; an empty table skips the walk and the interpolation.
// Requests are taken one at a time; the result register lets the next request in while a
// result still waits on the master side. No clearing pass: only written entries are used.
`include "keyframe_interpolator_core_defines.svh"

module keyframe_interpolator_core #(
  parameter int unsigned MAX_FRAMES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // now_ms[31:0], key_time_ms[47:32], key_x[63:48], key_y[79:64],
  // key_scale[95:80], key_alpha[103:96]
  input  logic [kfi_pkg::InW-1:0]   s_axis_tdata,
  // cmd[0]
  input  logic                      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // accepted[0], started[1], ended[2], frame_index[6:3], out_x[22:7], out_y[38:23],
  // out_scale[54:39], out_alpha[62:55], zero[63]
  output logic [kfi_pkg::OutW-1:0]  m_axis_tdata
);
  import kfi_pkg::*;

  localparam int unsigned AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned DivCntW = 4;  // 16 quotient bits

  // ---------------------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------------------
  kfi_state_e        state_q, state_d;
  kfi_lane_e         lane_q;
  logic [CW-1:0]     count_q;        // frames stored
  logic [AW-1:0]     cur_q;          // current frame
  logic [AW-1:0]     nxt_q;          // frame interpolated toward
  logic              started_q;
  logic [MsW-1:0]    anim_start_q;
  logic [MsW-1:0]    frame_start_q;
  logic [MsW-1:0]    now_q;
  logic [MsW-1:0]    elapsed_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [TimeW-1:0]  rem_q;          // divider remainder, always below the divisor
  logic [FracW-1:0]  f_q;            // fraction, shifts in quotient bits while dividing
  kfi_entry_t        a_q, b_q;

  // result being built
  logic              res_acc_q;
  logic              res_started_q;
  logic              res_ended_q;
  logic [FiW-1:0]    res_idx_q;
  logic [PixW-1:0]   res_x_q;
  logic [PixW-1:0]   res_y_q;
  logic [ScaleW-1:0] res_scale_q;
  logic [AlphaW-1:0] res_alpha_q;

  // output register
  logic              m_valid_q;
  logic [OutW-1:0]   m_data_q;

  // keyframe memory, one write and one registered read port
  kfi_entry_t        mem_q [MAX_FRAMES];
  kfi_entry_t        rd_q;
  logic [AW-1:0]     raddr;
  logic              wen;

  // ---------------------------------------------------------------------------------------
  // request unpacking
  // ---------------------------------------------------------------------------------------
  logic              s_fire;
  logic [MsW-1:0]    in_now;
  kfi_entry_t        in_entry;
  logic              out_free;
  logic              room;

  assign s_fire         = s_axis_tvalid && s_axis_tready;
  assign in_now         = s_axis_tdata[31:0];
  // key fields sit above now_ms in the same order as the entry struct
  assign in_entry       = s_axis_tdata[InW-1:MsW];
  assign out_free       = !m_valid_q || m_axis_tready;
  assign room           = count_q < CW'(MAX_FRAMES);
  assign wen            = s_fire && (s_axis_tuser == CmdAppend) && room;

  // next keyframe after idx, held at the last stored frame
  function automatic logic [AW-1:0] next_of(input logic [AW-1:0] idx,
                                            input logic [CW-1:0] cnt);
    logic [CW:0] inc;
    logic [CW-1:0] last;
    inc  = (CW+1)'(idx) + (CW+1)'(1);
    last = cnt - CW'(1);
    if ((CW+1)'(cnt) > inc) begin
      return inc[AW-1:0];
    end else begin
      return last[AW-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // datapath helpers
  // ---------------------------------------------------------------------------------------
  logic              advance;        // elapsed time has passed the next keyframe
  logic [AW-1:0]     nxt_adv;
  logic [MsW-1:0]    frame_d_ms;     // time since frame start
  logic              sat_frac;
  logic [TimeW:0]    rem_dbl;
  logic              qbit;
  logic [CW-1:0]     last_idx;

  assign advance    = elapsed_q > MsW'(rd_q.time_ms);
  assign nxt_adv    = next_of(nxt_q, count_q);
  assign frame_d_ms = now_q - frame_start_q;
  assign sat_frac   = (rd_q.time_ms == '0) || (frame_d_ms >= MsW'(rd_q.time_ms));
  assign rem_dbl    = {rem_q, 1'b0};
  assign qbit       = rem_dbl >= (TimeW+1)'(b_q.time_ms);
  assign last_idx   = count_q - CW'(1);

  // shared interpolator: a + (b - a) * f, rounded half up, in offset binary for signed fields
  logic [15:0]        la, lb;
  logic signed [16:0] diff;
  logic signed [34:0] prod;
  logic signed [34:0] acc;
  logic [15:0]        lv;

  always_comb begin
    case (lane_q)
      LANE_X: begin
        la = a_q.x ^ 16'h8000;
        lb = b_q.x ^ 16'h8000;
      end
      LANE_Y: begin
        la = a_q.y ^ 16'h8000;
        lb = b_q.y ^ 16'h8000;
      end
      LANE_SCALE: begin
        la = a_q.scale;
        lb = b_q.scale;
      end
      default: begin
        la = {8'h00, a_q.alpha};
        lb = {8'h00, b_q.alpha};
      end
    endcase
  end

  assign diff = $signed({1'b0, lb}) - $signed({1'b0, la});
  assign prod = diff * $signed({1'b0, f_q});
  assign acc  = $signed({3'b000, la, 16'h8000}) + prod;
  assign lv   = acc[31:16];

  // ---------------------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          state_d = (s_axis_tuser == CmdTick) ? S_RD_NEXT : S_DONE;
        end
      end
      S_RD_NEXT:  state_d = (count_q == '0) ? S_DONE : S_CHK_NEXT;
      S_CHK_NEXT: state_d = S_CHK_LAST;
      S_CHK_LAST: state_d = S_GET_A;
      S_GET_A:    state_d = S_GET_B;
      S_GET_B:    state_d = sat_frac ? S_LERP : S_DIV;
      S_DIV:      state_d = (div_cnt_q == '1) ? S_LERP : S_DIV;
      S_LERP:     state_d = (lane_q == LANE_ALPHA) ? S_DONE : S_LERP;
      S_DONE:     state_d = out_free ? S_IDLE : S_DONE;
      default:    state_d = S_IDLE;
    endcase
  end

  // sequencer: outputs (request ready, memory read address)
  always_comb begin
    s_axis_tready = 1'b0;
    raddr         = cur_q;
    unique case (state_q)
      S_IDLE:     s_axis_tready = 1'b1;
      S_RD_NEXT:  raddr = next_of(cur_q, count_q);
      S_CHK_NEXT: raddr = last_idx[AW-1:0];
      S_CHK_LAST: raddr = cur_q;
      S_GET_A:    raddr = nxt_q;
      default:    raddr = cur_q;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // keyframe memory
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem_q[count_q[AW-1:0]] <= in_entry;
    end
    rd_q <= mem_q[raddr];
  end

  // ---------------------------------------------------------------------------------------
  // control and animation registers
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      lane_q        <= LANE_X;
      count_q       <= '0;
      cur_q         <= '0;
      nxt_q         <= '0;
      started_q     <= 1'b0;
      anim_start_q  <= '0;
      frame_start_q <= '0;
      div_cnt_q     <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      // result register: load a finished result, else drain when taken
      if (state_q == S_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (wen) begin
            count_q <= count_q + CW'(1);
          end
          // first tick starts the animation
          if (s_fire && (s_axis_tuser == CmdTick) && !started_q) begin
            started_q     <= 1'b1;
            anim_start_q  <= in_now;
            frame_start_q <= in_now;
            cur_q         <= '0;
          end
        end
        S_RD_NEXT:  nxt_q <= next_of(cur_q, count_q);
        S_CHK_NEXT: begin
          if (advance) begin
            frame_start_q <= now_q;
            cur_q         <= nxt_q;
            nxt_q         <= nxt_adv;
          end
        end
        S_GET_B: begin
          div_cnt_q <= '0;
          lane_q    <= LANE_X;
        end
        S_DIV:  div_cnt_q <= div_cnt_q + DivCntW'(1);
        S_LERP: lane_q <= kfi_lane_e'(lane_q + 2'd1);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          now_q         <= in_now;
          res_acc_q     <= (s_axis_tuser == CmdTick) || room;
          res_started_q <= (s_axis_tuser == CmdTick) || started_q;
          res_ended_q   <= 1'b0;
          res_idx_q     <= '0;
          res_x_q       <= '0;
          res_y_q       <= '0;
          res_scale_q   <= '0;
          res_alpha_q   <= '0;
        end
      end
      S_RD_NEXT: begin
        elapsed_q <= now_q - anim_start_q;
        if (count_q == '0) begin
          res_ended_q <= 1'b1;
          res_idx_q   <= FiW'(cur_q);
        end
      end
      S_CHK_LAST: begin
        res_ended_q <= elapsed_q >= MsW'(rd_q.time_ms);
        res_idx_q   <= FiW'(cur_q);
      end
      S_GET_A: a_q <= rd_q;
      S_GET_B: begin
        b_q   <= rd_q;
        rem_q <= frame_d_ms[TimeW-1:0];
        f_q   <= sat_frac ? FracW'(17'h10000) : '0;
      end
      S_DIV: begin
        rem_q <= qbit ? TimeW'(rem_dbl - (TimeW+1)'(b_q.time_ms)) : rem_dbl[TimeW-1:0];
        f_q   <= {f_q[FracW-2:0], qbit};
      end
      S_LERP: begin
        case (lane_q)
          LANE_X:     res_x_q     <= lv ^ 16'h8000;
          LANE_Y:     res_y_q     <= lv ^ 16'h8000;
          LANE_SCALE: res_scale_q <= lv;
          default:    res_alpha_q <= lv[AlphaW-1:0];
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          m_data_q <= {1'b0, res_alpha_q, res_scale_q, res_y_q, res_x_q, res_idx_q,
                       res_ended_q, res_started_q, res_acc_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // ---------------------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------------------
  `KFI_ASSERT(a_count_bound, count_q <= CW'(MAX_FRAMES), "frame count beyond table depth")
  `KFI_ASSERT(a_cur_in_table, (count_q == '0) || ((CW+1)'(cur_q) < (CW+1)'(count_q)),
              "current frame outside stored frames")
  `KFI_ASSERT(a_div_started, (state_q != S_DIV && state_q != S_LERP) || started_q,
              "interpolation running before animation start")
  `KFI_ASSERT_NEXT(a_done_loads, state_q == S_DONE && out_free, m_valid_q && state_q == S_IDLE,
                   "finished result not presented")

endmodule
